// ===== hw/rtl/csf_pkg.sv =====
`default_nettype none

package csf_pkg;

	// Needle storage fixed by the register map: four 64-bit words
	localparam int NEEDLE_WORDS = 4;
	localparam int WORD_BITS    = 64;
	localparam int NEEDLE_BYTES = NEEDLE_WORDS * WORD_BITS / 8;

	localparam int CFG_INDEX_BITS = 3;
	localparam int LENGTH_BITS    = 6;
	localparam int INDEX_BITS     = 16;

	// Register indexes
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_LENGTH  = 3'd0;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_BYTES_0 = 3'd1;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_BYTES_1 = 3'd2;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_BYTES_2 = 3'd3;
	localparam logic [CFG_INDEX_BITS-1:0] REG_NEEDLE_BYTES_3 = 3'd4;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	typedef struct packed {
		logic [7:0] hay_byte;
		logic       last_byte;
	} in_beat_t;

	typedef struct packed {
		logic                  found;
		logic [INDEX_BITS-1:0] match_index;
	} out_beat_t;

	// Per-beat control broadcast to every cell
	typedef struct packed {
		logic shift;
		logic clear;
	} cell_ctrl_t;

	// Fold A-Z to a-z, everything else unchanged
	function automatic logic [7:0] fold_ascii(input logic [7:0] b);
		logic [7:0] r;
		r = b;
		if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) begin
			r = b + CASE_OFFSET;
		end
		return r;
	endfunction

endpackage

`default_nettype wire

// ===== hw/rtl/csf_cell.sv =====
`default_nettype none

// One needle position: holds the partial-match bit for needle bytes 0..k
module csf_cell
	import csf_pkg::*;
(
	input  wire logic       clk,
	input  wire logic       arst_n,
	input  wire cell_ctrl_t ctrl,
	input  wire logic [7:0] hay_fold,
	input  wire logic       hay_nz,
	input  wire logic [7:0] needle_byte,
	input  wire logic       in_use,
	input  wire logic       is_end,
	input  wire logic       prev_bit,
	output logic            match_bit,
	output logic            end_hit
);

	logic match_q;
	logic hit;
	logic next_bit;

	// Compare against the folded needle byte; zero haystack bytes never hit
	assign hit      = hay_nz && in_use && (hay_fold == fold_ascii(needle_byte));
	assign next_bit = prev_bit & hit;
	assign end_hit  = next_bit & is_end;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			match_q <= 1'b0;
		end else if (ctrl.clear) begin
			match_q <= 1'b0;
		end else if (ctrl.shift) begin
			match_q <= next_bit;
		end
	end

	assign match_bit = match_q;

endmodule

`default_nettype wire

// ===== hw/rtl/caseless_substring_find_unit.sv =====
`default_nettype none

// Caseless substring finder.
// Configure the needle through cfg_we/cfg_index/cfg_data while the block is
// idle: index 0 is the needle length, indexes 1 to 4 hold needle bytes 0..31
// (byte k at bits 8*(k mod 8) upward of word k/8). Other indexes are ignored.
// Haystack bytes stream in on the input channel, one beat per byte, with
// last_byte set on the final byte. A-Z compare equal to a-z; a zero byte
// never matches. Each beat enters a row of MAX_NEEDLE cells that update
// their partial-match bits in the cycle it is accepted (until the first
// match), so one byte is taken every clock while the input is not stalled.
// The beat marked last produces one output beat (found, match_index) in the
// output register in the cycle after it is accepted; other beats produce none.
// The output register frees the input side: input is stalled only while a
// result is held and the output is stalled.
// Reset clears the needle registers, the search state and the output valid.
// The position counter saturates at 2^POSITION_BITS - 1.
module caseless_substring_find_unit
	import csf_pkg::*;
#(
	parameter int MAX_NEEDLE    = 32,
	parameter int POSITION_BITS = 16
) (
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_beat_t             in_data,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_beat_t                 out_data,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_INDEX_BITS-1:0] cfg_index,
	input  wire logic [WORD_BITS-1:0] cfg_data
);

	localparam int LEN_W = $clog2(MAX_NEEDLE + 1);

	logic [LENGTH_BITS-1:0]             needle_length_q;
	logic [NEEDLE_BYTES*8-1:0]          needle_q;
	logic [POSITION_BITS-1:0]           pos_q;
	logic                               match_seen_q;
	logic [POSITION_BITS-1:0]           start_q;
	logic                               out_valid_q;
	out_beat_t                          out_data_q;

	logic [LEN_W-1:0]                   len;
	logic                               len_zero;
	logic                               active;
	logic                               accept;
	cell_ctrl_t                         ctrl;
	logic [7:0]                         hay_fold;
	logic                               hay_nz;
	logic [MAX_NEEDLE:0]                chain;
	logic [MAX_NEEDLE-1:0]              end_hits;
	logic                               hit_now;
	logic [POSITION_BITS-1:0]           start_now;
	logic [POSITION_BITS+INDEX_BITS-1:0] start_wide;
	out_beat_t                          result;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			needle_length_q <= '0;
			needle_q        <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_NEEDLE_LENGTH:  needle_length_q <= cfg_data[LENGTH_BITS-1:0];
				REG_NEEDLE_BYTES_0: needle_q[0*WORD_BITS +: WORD_BITS] <= cfg_data;
				REG_NEEDLE_BYTES_1: needle_q[1*WORD_BITS +: WORD_BITS] <= cfg_data;
				REG_NEEDLE_BYTES_2: needle_q[2*WORD_BITS +: WORD_BITS] <= cfg_data;
				REG_NEEDLE_BYTES_3: needle_q[3*WORD_BITS +: WORD_BITS] <= cfg_data;
				default: ;
			endcase
		end
	end

	// Effective length, clamped to the cell count
	assign len = (32'(needle_length_q) > MAX_NEEDLE) ? LEN_W'(MAX_NEEDLE)
	                                                 : LEN_W'(needle_length_q);
	assign len_zero = (len == '0);

	// Handshake
	assign in_stall = out_valid_q & out_stall;
	assign accept   = in_valid & ~in_stall;
	assign active   = ~len_zero & ~match_seen_q;

	assign ctrl.shift = accept & active;
	assign ctrl.clear = accept & in_data.last_byte;

	assign hay_fold = fold_ascii(in_data.hay_byte);
	assign hay_nz   = (in_data.hay_byte != 8'h00);

	// Row of match cells
	assign chain[0] = 1'b1;

	for (genvar k = 0; k < MAX_NEEDLE; k++) begin : g_cell
		logic [7:0] nb;
		if (k < NEEDLE_BYTES) begin : g_byte
			assign nb = needle_q[k*8 +: 8];
		end else begin : g_zero
			assign nb = 8'h00;
		end

		csf_cell u_cell (
			.clk         (clk),
			.arst_n      (arst_n),
			.ctrl        (ctrl),
			.hay_fold    (hay_fold),
			.hay_nz      (hay_nz),
			.needle_byte (nb),
			.in_use      (LEN_W'(k) < len),
			.is_end      (len == LEN_W'(k + 1)),
			.prev_bit    (chain[k]),
			.match_bit   (chain[k+1]),
			.end_hit     (end_hits[k])
		);
	end

	assign hit_now   = active & (|end_hits);
	assign start_now = pos_q - POSITION_BITS'(len) + POSITION_BITS'(1);

	// Position counter and first-match tracking
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pos_q        <= '0;
			match_seen_q <= 1'b0;
			start_q      <= '0;
		end else if (accept) begin
			if (in_data.last_byte) begin
				pos_q        <= '0;
				match_seen_q <= 1'b0;
				start_q      <= '0;
			end else begin
				if (pos_q != '1) begin
					pos_q <= pos_q + POSITION_BITS'(1);
				end
				if (hit_now) begin
					match_seen_q <= 1'b1;
					start_q      <= start_now;
				end
			end
		end
	end

	// Result for the last beat
	always_comb begin
		start_wide         = '0;
		result.found       = 1'b0;
		result.match_index = '0;
		if (len_zero) begin
			result.found = 1'b1;
		end else if (match_seen_q) begin
			start_wide         = {{INDEX_BITS{1'b0}}, start_q};
			result.found       = 1'b1;
			result.match_index = start_wide[INDEX_BITS-1:0];
		end else if (hit_now) begin
			start_wide         = {{INDEX_BITS{1'b0}}, start_now};
			result.found       = 1'b1;
			result.match_index = start_wide[INDEX_BITS-1:0];
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept && in_data.last_byte) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept && in_data.last_byte) begin
			out_data_q <= result;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_data_q;

endmodule

`default_nettype wire

// ===== verif/caseless_substring_find_unit_tb.sv =====
module caseless_substring_find_unit_tb;
	timeunit 1ns;
	timeprecision 1ps;

	import csf_pkg::*;

	typedef logic [7:0] hay_q_t [$];

	// Needle word registers in order, and the first index with no register behind it
	localparam logic [CFG_INDEX_BITS-1:0] WORD_REG [NEEDLE_WORDS] = '{
		REG_NEEDLE_BYTES_0, REG_NEEDLE_BYTES_1, REG_NEEDLE_BYTES_2, REG_NEEDLE_BYTES_3
	};
	localparam logic [CFG_INDEX_BITS-1:0] REG_UNMAPPED_FIRST = REG_NEEDLE_BYTES_3 + 3'd1;
	localparam int LENGTH_TOP = (1 << LENGTH_BITS) - 1;

	// Shift-and search tracker: mirrors the needle registers and the search state,
	// queues the result each haystack should produce and checks what comes out
	class match_tracker;
		logic [LENGTH_BITS-1:0] needle_len;
		logic [WORD_BITS-1:0]   needle_word [NEEDLE_WORDS];
		logic [31:0]            partial;
		logic [INDEX_BITS-1:0]  position;
		bit                     seen;
		logic [INDEX_BITS-1:0]  first_start;
		out_beat_t              pending [$];
		int                     errors;
		int                     checked;

		function new();
			needle_len = '0;
			foreach (needle_word[w]) needle_word[w] = '0;
			errors = 0;
			checked = 0;
			clear_search();
		endfunction

		function void clear_search();
			partial = '0;
			position = '0;
			seen = 1'b0;
			first_start = '0;
		endfunction

		function void write_register(logic [CFG_INDEX_BITS-1:0] idx,
				logic [WORD_BITS-1:0] data);
			case (idx)
				REG_NEEDLE_LENGTH:  needle_len = data[LENGTH_BITS-1:0];
				REG_NEEDLE_BYTES_0: needle_word[0] = data;
				REG_NEEDLE_BYTES_1: needle_word[1] = data;
				REG_NEEDLE_BYTES_2: needle_word[2] = data;
				REG_NEEDLE_BYTES_3: needle_word[3] = data;
				default: ;	// unmapped index, no effect
			endcase
		endfunction

		function logic [7:0] to_lower(logic [7:0] b);
			if (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z) return b + CASE_OFFSET;
			return b;
		endfunction

		function void take_hay_beat(in_beat_t b);
			int         len;
			logic [31:0] hit;
			logic [7:0]  nb;
			out_beat_t   res;
			len = (needle_len > NEEDLE_BYTES) ? NEEDLE_BYTES : int'(needle_len);
			// partial-match vector only moves until the first full match
			if (len > 0 && !seen) begin
				hit = '0;
				if (b.hay_byte != 8'h00) begin
					for (int k = 0; k < len; k++) begin
						nb = needle_word[k / 8][(k % 8) * 8 +: 8];
						if (to_lower(b.hay_byte) == to_lower(nb)) hit[k] = 1'b1;
					end
				end
				partial = ((partial << 1) | 32'd1) & hit;
				if (partial[len-1]) begin
					seen = 1'b1;
					first_start = position - (len - 1);
				end
			end
			if (position != '1) position++;
			if (b.last_byte) begin
				res.found = (len == 0) || seen;
				res.match_index = (len != 0 && seen) ? first_start : '0;
				pending.push_back(res);
				clear_search();
			end
		endfunction

		function void check_match_result(out_beat_t r);
			out_beat_t want;
			if (pending.size() == 0) begin
				errors++;
				$display("%0t: result beat with none pending: found=%0b match_index=%0d",
					$time, r.found, r.match_index);
				return;
			end
			want = pending.pop_front();
			checked++;
			if (r.found !== want.found) begin
				errors++;
				$display("%0t: found mismatch: expected %0b, actual %0b",
					$time, want.found, r.found);
			end
			if (r.match_index !== want.match_index) begin
				errors++;
				$display("%0t: match_index mismatch: expected %0d, actual %0d",
					$time, want.match_index, r.match_index);
			end
		endfunction
	endclass

	logic                      clk = 1'b0;
	logic                      arst_n = 1'b0;
	logic                      in_valid = 1'b0;
	logic                      in_stall;
	in_beat_t                  in_data = '0;
	logic                      out_valid;
	logic                      out_stall = 1'b0;
	out_beat_t                 out_data;
	logic                      cfg_we = 1'b0;
	logic [CFG_INDEX_BITS-1:0] cfg_index = '0;
	logic [WORD_BITS-1:0]      cfg_data = '0;

	match_tracker tracker = new();

	int         send_idle_pct = 0;
	int         recv_stall_pct = 0;
	bit         hold_request = 1'b0;
	int         hay_bytes_sent = 0;
	int         haystacks_sent = 0;
	int         settings_used = 0;
	logic [7:0] needle_text [NEEDLE_BYTES];
	int         needle_len_sel = 0;

	caseless_substring_find_unit DUT (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_stall  (in_stall),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	initial begin
		forever #5 clk = ~clk;
	end

	// Output side: random stall, or a long hold-off when asked for
	initial begin : receiver
		int hold_left;
		hold_left = 0;
		forever begin
			@(posedge clk);
			if (hold_request) begin
				hold_left = 300;
				hold_request = 1'b0;
			end
			if (hold_left > 0) begin
				out_stall <= 1'b1;
				hold_left--;
			end else begin
				out_stall <= ($urandom_range(99) < recv_stall_pct);
			end
		end
	end

	// Beat monitor: values seen here are the ones before the edge
	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) tracker.check_match_result(out_data);
			if (in_valid && !in_stall) tracker.take_hay_beat(in_data);
		end
	end

	function automatic logic [7:0] needle_char();
		case ($urandom_range(11))
			0: return "a";
			1: return "b";
			2: return "z";
			3: return "A";
			4: return "Z";
			5: return "@";
			6: return "[";
			7: return 8'h60;
			8: return "{";
			default: return 8'($urandom_range(255));
		endcase
	endfunction

	function automatic logic [7:0] flip_case(input logic [7:0] b);
		if (((b >= "a" && b <= "z") || (b >= CHAR_UPPER_A && b <= CHAR_UPPER_Z))
				&& $urandom_range(1) == 1)
			return b ^ CASE_OFFSET;
		return b;
	endfunction

	// Haystack built from needle prefixes in mixed case and noise bytes, or from noise alone
	function automatic hay_q_t make_haystack();
		hay_q_t hay;
		int     eff;
		int     target;
		int     piece;
		eff = (needle_len_sel > NEEDLE_BYTES) ? NEEDLE_BYTES : needle_len_sel;
		target = $urandom_range(1, eff + 10);
		if ($urandom_range(9) == 0) begin
			repeat (target) hay.push_back(8'($urandom_range(255)));
			return hay;
		end
		while (hay.size() < target) begin
			case ($urandom_range(9))
				0, 1, 2, 3: begin
					if (eff > 0) begin
						piece = ($urandom_range(2) == 0) ? $urandom_range(1, eff) : eff;
						for (int k = 0; k < piece; k++) hay.push_back(flip_case(needle_text[k]));
					end
				end
				4: hay.push_back(8'($urandom_range(255)));
				default: hay.push_back(flip_case(needle_char()));
			endcase
		end
		return hay;
	endfunction

	task automatic send_beat(input logic [7:0] b, input logic last);
		while ($urandom_range(99) < send_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		in_data <= '{hay_byte: b, last_byte: last};
		@(posedge clk);
		while (in_stall) @(posedge clk);
	endtask

	task automatic send_haystack(input hay_q_t hay);
		foreach (hay[i]) send_beat(hay[i], i == hay.size() - 1);
		hay_bytes_sent += hay.size();
		haystacks_sent++;
	endtask

	task automatic send_text(input string s);
		hay_q_t hay;
		for (int i = 0; i < s.len(); i++) hay.push_back(s[i]);
		send_haystack(hay);
	endtask

	// Drop valid and let every pending result drain before touching registers
	task automatic end_round();
		in_valid <= 1'b0;
		@(posedge clk);
		while (tracker.pending.size() != 0) @(posedge clk);
		repeat (4) @(posedge clk);
	endtask

	// Length (junk above the field), all four words, then one unmapped index
	task automatic program_needle();
		logic [CFG_INDEX_BITS-1:0] idx;
		logic [WORD_BITS-1:0]      data;
		for (int r = 0; r < NEEDLE_WORDS + 2; r++) begin
			if (r == 0) begin
				idx = REG_NEEDLE_LENGTH;
				data = {$urandom, $urandom};
				data[LENGTH_BITS-1:0] = needle_len_sel[LENGTH_BITS-1:0];
			end else if (r <= NEEDLE_WORDS) begin
				idx = WORD_REG[r-1];
				for (int b = 0; b < 8; b++) data[b*8 +: 8] = needle_text[(r-1)*8 + b];
			end else begin
				idx = REG_UNMAPPED_FIRST + 3'($urandom_range(2));
				data = {$urandom, $urandom};
			end
			cfg_we <= 1'b1;
			cfg_index <= idx;
			cfg_data <= data;
			@(posedge clk);
			tracker.write_register(idx, data);
		end
		cfg_we <= 1'b0;
		settings_used++;
	endtask

	task automatic set_needle(input string s, input int len);
		foreach (needle_text[k]) needle_text[k] = (k < s.len()) ? s[k] : 8'h00;
		needle_len_sel = len;
		program_needle();
	endtask

	task automatic pick_needle();
		int zero_at;
		foreach (needle_text[k]) needle_text[k] = needle_char();
		case ($urandom_range(9))
			0: needle_len_sel = 0;
			1: needle_len_sel = NEEDLE_BYTES;
			2: needle_len_sel = $urandom_range(NEEDLE_BYTES + 1, LENGTH_TOP);
			3: begin
				needle_len_sel = $urandom_range(1, 4);
				foreach (needle_text[k]) needle_text[k] = 8'hFF;
			end
			4: begin
				needle_len_sel = $urandom_range(2, 6);
				zero_at = $urandom_range(0, needle_len_sel - 1);
				needle_text[zero_at] = 8'h00;
			end
			default: needle_len_sel = $urandom_range(1, 6);
		endcase
		program_needle();
	endtask

	task automatic run_random(input int send_pct, input int recv_pct, input int items);
		hay_q_t hay;
		int     sent;
		send_idle_pct = send_pct;
		recv_stall_pct = recv_pct;
		sent = 0;
		while (sent < items) begin
			pick_needle();
			repeat ($urandom_range(3, 8)) begin
				hay = make_haystack();
				send_haystack(hay);
				sent += hay.size();
			end
			end_round();
		end
	endtask

	initial begin : stimulus
		hay_q_t hay;
		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Needle is empty out of reset: always found at zero
		hay = '{8'h00, 8'hFF};
		send_haystack(hay);
		end_round();

		// Case folding both ways; bytes after a match leave the result alone
		set_needle("aZ", 2);
		send_text("xAz");
		send_text("AZaz");
		end_round();

		// Neighbors of the letter ranges are not folded
		set_needle("@[", 2);
		hay = '{8'h60, 8'h7B, 8'h40, 8'h5B};
		send_haystack(hay);
		end_round();

		// Zero byte inside the needle never matches, even a zero hay byte
		set_needle("a", 2);
		hay = '{"a", 8'h00, "a"};
		send_haystack(hay);
		end_round();

		// All-ones needle words
		foreach (needle_text[k]) needle_text[k] = 8'hFF;
		needle_len_sel = 1;
		program_needle();
		hay = '{8'h00};
		send_haystack(hay);
		hay = '{8'hFF};
		send_haystack(hay);
		end_round();

		// Empty needle with stale bytes, then a length past the needle store
		set_needle("qq", 0);
		send_text("q");
		end_round();
		set_needle("ab", LENGTH_TOP);
		send_text("ab");
		end_round();

		run_random(0, 0, 120);
		run_random(47, 0, 120);
		run_random(0, 47, 120);
		run_random(33, 33, 120);

		// Output held off for a long stretch while short haystacks keep coming
		send_idle_pct = 0;
		recv_stall_pct = 10;
		pick_needle();
		hold_request = 1'b1;
		repeat (60) begin
			hay.delete();
			hay.push_back(flip_case(needle_text[0]));
			if ($urandom_range(2) == 0) hay.push_back(flip_case(needle_char()));
			send_haystack(hay);
		end
		end_round();

		run_random(15, 15, 80);

		end_round();
		repeat (10) @(posedge clk);
		$display("Streamed %0d haystack bytes in %0d haystacks over %0d needle settings,",
			hay_bytes_sent, haystacks_sent, settings_used);
		$display("checked %0d results under mixed sender gaps and receiver hold-offs.",
			tracker.checked);
		if (tracker.errors == 0) begin
			$display("simulation ok");
		end else begin
			$display("simulation failed");
		end
		$finish;
	end

	initial begin : watchdog
		#3ms;
		$display("simulation failed");
		$finish;
	end

endmodule
